/* rtl/core/bounded_priority_queue_macros.svh */
// Assertion macros shared by the bounded priority queue RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BOUNDED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded_priority_queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded_priority_queue: next-cycle check failed");

`endif

/* rtl/core/bpq_pkg.sv */
// Package for the bounded priority queue: operation and status codes,
// cell command struct and configuration port constants. No dependencies.
package bpq_pkg;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } bpq_op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } bpq_status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic       en;
      bpq_op_type op;
   } bpq_cmd_type;

   localparam int CFG_W        = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_CAPACITY = 0;

endpackage

/* rtl/core/bpq_cell.sv */
// One slot of the sorted chain: holds a priority and a tag.
// Depends on bpq_pkg.
module bpq_cell #(
   parameter int PRIO_W = 8,
   parameter int TAG_W  = 16
) (
   input  logic                clock,
   input  bpq_pkg::bpq_cmd_type cmd,
   input  logic                occupied,
   input  logic [PRIO_W-1:0]   new_prio,
   input  logic [TAG_W-1:0]    new_tag,
   input  logic                left_less,
   input  logic [PRIO_W-1:0]   left_prio,
   input  logic [TAG_W-1:0]    left_tag,
   input  logic [PRIO_W-1:0]   right_prio,
   input  logic [TAG_W-1:0]    right_tag,
   output logic                self_less,
   output logic [PRIO_W-1:0]   prio,
   output logic [TAG_W-1:0]    tag
);
   import bpq_pkg::*;

   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   // Stored entry stays ahead of the new one only when strictly smaller.
   assign self_less = occupied && (prio_ff < new_prio);

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            if (!self_less) begin
               if (left_less) begin
                  prio_in = new_prio;
                  tag_in  = new_tag;
               end else begin
                  prio_in = left_prio;
                  tag_in  = left_tag;
               end
            end
         end
         OP_REMOVE: begin
            prio_in = right_prio;
            tag_in  = right_tag;
         end
         default: begin
            prio_in = prio_ff;
            tag_in  = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         prio_ff <= prio_in;
         tag_ff  <= tag_in;
      end
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule

/* rtl/core/bpq_chain.sv */
// Row of bpq_cell slots with front and back selection.
// Depends on bpq_pkg and bpq_cell.
module bpq_chain #(
   parameter int DEPTH  = 16,
   parameter int PRIO_W = 8,
   parameter int TAG_W  = 16,
   parameter int CNT_W  = 5
) (
   input  logic                 clock,
   input  bpq_pkg::bpq_cmd_type cmd,
   input  logic [CNT_W-1:0]     count,
   input  logic [PRIO_W-1:0]    new_prio,
   input  logic [TAG_W-1:0]     new_tag,
   output logic [PRIO_W-1:0]    front_prio,
   output logic [TAG_W-1:0]     front_tag,
   output logic [PRIO_W-1:0]    back_prio,
   output logic [TAG_W-1:0]     back_tag
);
   import bpq_pkg::*;

   logic [PRIO_W-1:0] prio_q [DEPTH];
   logic [TAG_W-1:0]  tag_q  [DEPTH];
   logic [DEPTH-1:0]  less_q;
   logic [DEPTH-1:0]  occ;
   logic [CNT_W-1:0]  back_idx;

   assign back_idx = count - 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PRIO_W-1:0] l_prio, r_prio;
      logic [TAG_W-1:0]  l_tag, r_tag;
      logic              l_less;

      assign occ[i] = CNT_W'(i) < count;

      if (i == 0) begin : g_head
         assign l_less = 1'b1;
         assign l_prio = new_prio;
         assign l_tag  = new_tag;
      end else begin : g_body
         assign l_less = less_q[i-1];
         assign l_prio = prio_q[i-1];
         assign l_tag  = tag_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_prio = prio_q[i];
         assign r_tag  = tag_q[i];
      end else begin : g_next
         assign r_prio = prio_q[i+1];
         assign r_tag  = tag_q[i+1];
      end

      bpq_cell #(
         .PRIO_W(PRIO_W),
         .TAG_W (TAG_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occ[i]),
         .new_prio  (new_prio),
         .new_tag   (new_tag),
         .left_less (l_less),
         .left_prio (l_prio),
         .left_tag  (l_tag),
         .right_prio(r_prio),
         .right_tag (r_tag),
         .self_less (less_q[i]),
         .prio      (prio_q[i]),
         .tag       (tag_q[i])
      );
   end

   // Front is slot 0; back is an AND-OR pick of the last occupied slot.
   always_comb begin
      front_prio = occ[0] ? prio_q[0] : '0;
      front_tag  = occ[0] ? tag_q[0]  : '0;
      back_prio  = '0;
      back_tag   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (occ[i] && (back_idx == CNT_W'(i))) begin
            back_prio = back_prio | prio_q[i];
            back_tag  = back_tag  | tag_q[i];
         end
      end
   end

endmodule

/* rtl/core/bounded_priority_queue.sv */
// Bounded priority queue top level: stream handshake, capacity register
// and result register around bpq_chain. Depends on bpq_pkg, bpq_chain, macros.
//
// Keeps up to capacity_limit tagged entries sorted by ascending priority in a
// row of cells; an insert goes ahead of the first entry whose priority is not
// smaller (newest first among equals), a remove drops the front. Each request
// transfer gives one response transfer with status (tuser), the front and back
// entries, the count and empty/full flags. The cells update at the request
// transfer; the response register is then loaded from the cell row (back entry
// picked by the count) once the register is free. A new request is taken
// while a finished response still waits on rsp_tready. capacity_limit (csr
// addresses 0 to 3) only grows: a write saturates at QUEUE_DEPTH and is dropped unless
// larger than the current value. No clearing pass: slots above the count are
// never read.
module bounded_priority_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
   localparam int IN_RAW_W     = PRIORITY_BITS + TAG_BITS,
   localparam int IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8,
   localparam int OUT_RAW_W    = 2 * PRIORITY_BITS + 2 * TAG_BITS + CNT_W + 2,
   localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [IN_DATA_W-1:0]             req_tdata,  // priority_req, doc_tag
   input  logic                             req_tuser,  // mode
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // front_priority, front_tag, back_priority, back_tag, entry_count,
   // is_empty, is_full
   output logic [OUT_DATA_W-1:0]            rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // status
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bpq_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         cap_ff, cap_in;
   logic                     pend_ff, pend_in;
   bpq_status_type           stat_ff, stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_RAW_W-1:0]     rsp_data_ff, rsp_data_in;
   bpq_status_type           rsp_stat_ff, rsp_stat_in;

   logic                     accept;
   logic                     load_rsp;
   bpq_op_type               op;
   logic                     full_now;
   logic                     do_ins;
   logic                     do_rem;
   logic                     rem_refused;
   bpq_cmd_type              cmd;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic [TAG_BITS-1:0]      new_tag;
   logic [PRIORITY_BITS-1:0] front_prio, back_prio;
   logic [TAG_BITS-1:0]      front_tag, back_tag;
   logic                     csr_wr;
   logic                     csr_hit;
   logic [CFG_W-1:0]         wr_val;
   logic [CNT_W-1:0]         wr_sat;

   // ---------------- request side ----------------
   // Hold off new requests while one waits for its response to be built.
   assign req_tready = !pend_ff;
   assign accept     = req_tvalid && req_tready;
   assign op         = bpq_op_type'(req_tuser);
   assign new_prio   = req_tdata[PRIORITY_BITS-1:0];
   assign new_tag    = req_tdata[IN_RAW_W-1:PRIORITY_BITS];

   // Full when the count reaches either the limit or the physical depth.
   assign full_now = (count_ff >= cap_ff) || (count_ff == DEPTH_CNT);
   assign do_ins   = accept && (op == OP_INSERT) && !full_now;
   assign do_rem   = accept && (op == OP_REMOVE) && (count_ff != '0);
   assign rem_refused = accept && (op == OP_REMOVE) && (count_ff == '0);

   assign cmd.en = do_ins || do_rem;
   assign cmd.op = op;

   always_comb begin
      count_in = count_ff;
      stat_in  = stat_ff;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (do_rem) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         unique case (op)
            OP_INSERT: stat_in = full_now ? STAT_FULL : STAT_DONE;
            OP_REMOVE: stat_in = (count_ff == '0) ? STAT_EMPTY : STAT_DONE;
            default:   stat_in = STAT_DONE;
         endcase
      end
   end

   // ---------------- cell row ----------------
   bpq_chain #(
      .DEPTH (QUEUE_DEPTH),
      .PRIO_W(PRIORITY_BITS),
      .TAG_W (TAG_BITS),
      .CNT_W (CNT_W)
   ) u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .count     (count_ff),
      .new_prio  (new_prio),
      .new_tag   (new_tag),
      .front_prio(front_prio),
      .front_tag (front_tag),
      .back_prio (back_prio),
      .back_tag  (back_tag)
   );

   // ---------------- response side ----------------
   // Build the response once the cells have settled and the register is free.
   assign load_rsp = pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_stat_in  = stat_ff;
         rsp_data_in  = {(count_ff == cap_ff), (count_ff == '0), count_ff,
                         back_tag, back_prio, front_tag, front_prio};
      end
      if (accept) begin
         pend_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_stat_ff;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == 1'(REG_CAPACITY));
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign wr_val     = csr_pwdata[CFG_W-1:0];

   // Saturate at the depth, then only grow the limit.
   always_comb begin
      if (32'(wr_val) > 32'(QUEUE_DEPTH)) begin
         wr_sat = DEPTH_CNT;
      end else begin
         wr_sat = CNT_W'(wr_val);
      end
      cap_in = cap_ff;
      if (csr_wr && (32'(wr_sat) > 32'(cap_ff))) begin
         cap_in = wr_sat;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_ff) : '0;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= DEPTH_CNT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stat_ff      <= STAT_DONE;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         stat_ff      <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // ---------------- checks ----------------
`include "bounded_priority_queue_macros.svh"

   `BPQ_ASSERT_NOW(a_count_le_cap, clock, reset, 1'b1, count_ff <= cap_ff)
   `BPQ_ASSERT_NOW(a_cap_le_depth, clock, reset, 1'b1, cap_ff <= DEPTH_CNT)
   `BPQ_ASSERT_NEXT(a_ins_grows, clock, reset, do_ins, count_ff == $past(count_ff) + 1'b1)
   `BPQ_ASSERT_NEXT(a_rem_empty, clock, reset, rem_refused, stat_ff == STAT_EMPTY)
   `BPQ_ASSERT_NEXT(a_pend_after_accept, clock, reset, accept, pend_ff && !req_tready)

endmodule
